// ----- rtl/tklru_pkg.sv -----
// Shared types and constants for the tile key LRU cache directory.
package tklru_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam logic [17:0] MAX_TILE_BYTES = 18'd131072;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_FLUSH  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        logic        match_found;
        logic        inv_found;
        logic        has_min;
        logic [31:0] min_stamp;
        logic [16:0] match_bytes;
    } srch_t;

    typedef struct packed {
        logic        full;
        logic        stamp_only;
        logic        flush;
        logic [7:0]  zoom;
        logic [15:0] col;
        logic [15:0] row;
        logic [16:0] bytes;
        logic [31:0] stamp;
    } cmd_t;

endpackage

// ----- rtl/tklru_cell.sv -----
// One directory entry plus one stage of the search token chain.
module tklru_cell #(
    parameter int ENTRIES = tklru_pkg::ENTRIES_DEF,
    parameter int IDX     = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       tin_act,
    input  tklru_pkg::srch_t                           tin,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tin_match_idx,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tin_inv_idx,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tin_min_idx,
    input  logic [$clog2(ENTRIES + 1)-1:0]             tin_count,
    output logic                                       tout_act,
    output tklru_pkg::srch_t                           tout,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tout_match_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tout_inv_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] tout_min_idx,
    output logic [$clog2(ENTRIES + 1)-1:0]             tout_count,
    input  tklru_pkg::cmd_t                            cmd,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] cmd_idx
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic              valid_reg;
    logic [7:0]        zoom_reg;
    logic [15:0]       col_reg;
    logic [15:0]       row_reg;
    logic [16:0]       bytes_reg;
    logic [31:0]       stamp_reg;

    logic              act_reg;
    tklru_pkg::srch_t  srch_reg;
    tklru_pkg::srch_t  srch_next;
    logic [IDX_W-1:0]  midx_reg;
    logic [IDX_W-1:0]  midx_next;
    logic [IDX_W-1:0]  iidx_reg;
    logic [IDX_W-1:0]  iidx_next;
    logic [IDX_W-1:0]  nidx_reg;
    logic [IDX_W-1:0]  nidx_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              key_eq;
    logic              sel;

    always_comb
    begin
        key_eq    = valid_reg && (zoom_reg == cmd.zoom) && (col_reg == cmd.col)
                    && (row_reg == cmd.row);
        srch_next = tin;
        midx_next = tin_match_idx;
        iidx_next = tin_inv_idx;
        nidx_next = tin_min_idx;
        cnt_next  = tin_count + CNT_W'(valid_reg);
        if (!tin.match_found && key_eq)
        begin
            srch_next.match_found = 1'b1;
            srch_next.match_bytes = bytes_reg;
            midx_next             = MY_IDX;
        end
        if (!tin.inv_found && !valid_reg)
        begin
            srch_next.inv_found = 1'b1;
            iidx_next           = MY_IDX;
        end
        if (valid_reg && (!tin.has_min || (stamp_reg < tin.min_stamp)))
        begin
            srch_next.has_min   = 1'b1;
            srch_next.min_stamp = stamp_reg;
            nidx_next           = MY_IDX;
        end
        sel = (cmd_idx == MY_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            act_reg <= tin_act;
            if (cmd.flush)
            begin
                valid_reg <= 1'b0;
            end
            else if (cmd.full && sel)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        srch_reg <= srch_next;
        midx_reg <= midx_next;
        iidx_reg <= iidx_next;
        nidx_reg <= nidx_next;
        cnt_reg  <= cnt_next;
        if (cmd.full && sel)
        begin
            zoom_reg  <= cmd.zoom;
            col_reg   <= cmd.col;
            row_reg   <= cmd.row;
            bytes_reg <= cmd.bytes;
        end
        if ((cmd.full || cmd.stamp_only) && sel)
        begin
            stamp_reg <= cmd.stamp;
        end
    end

    assign tout_act       = act_reg;
    assign tout           = srch_reg;
    assign tout_match_idx = midx_reg;
    assign tout_inv_idx   = iidx_reg;
    assign tout_min_idx   = nidx_reg;
    assign tout_count     = cnt_reg;

endmodule

// ----- rtl/tile_key_lru_cache_directory.sv -----
// Top level of the tile key LRU cache directory: request control, cell chain, result register.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------------
//   in      | in_valid, in_stall | func, zoom, tile_x, tile_y, tile_size
//   out     | out_valid,out_stall| hit, slot, stored_size, accepted, use_fallback,
//           |                    | valid_count
//
// One request at a time: after transfer, the launch register starts the search token, which walks
// the cell chain one cell per cycle; the capture register then takes the chain result, and the
// commit writes the result register. No new request is taken until the previous one has committed.
// The next request transfers in the cycle after commit, while the result may still wait.
// Reset clears all valid bits, the tick and control; no clearing pass.
// A stalled result holds the commit of the following request until it drains.
module tile_key_lru_cache_directory #(
    parameter int ENTRIES = tklru_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  zoom,
    input  logic [15:0] tile_x,
    input  logic [15:0] tile_y,
    input  logic [17:0] tile_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [2:0]  slot,
    output logic [17:0] stored_size,
    output logic        accepted,
    output logic        use_fallback,
    output logic [3:0]  valid_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               start_reg;
    logic [31:0]        tick_reg;
    logic [31:0]        tick_next;
    logic [31:0]        tick_inc;

    tklru_pkg::func_t   func_reg;
    logic [7:0]         zoom_reg;
    logic [15:0]        x_reg;
    logic [15:0]        y_reg;
    logic [17:0]        size_reg;

    tklru_pkg::srch_t   fin_reg;
    logic [IDX_W-1:0]   fin_midx_reg;
    logic [IDX_W-1:0]   fin_iidx_reg;
    logic [IDX_W-1:0]   fin_nidx_reg;
    logic [CNT_W-1:0]   fin_cnt_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic [2:0]         slot_reg;
    logic [17:0]        size_out_reg;
    logic               accepted_reg;
    logic               fallback_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               size_ok;
    logic               wr_full;
    logic               wr_stamp;
    logic               wr_flush;
    logic               res_hit;
    logic [2:0]         res_slot;
    logic [17:0]        res_size;
    logic               res_acc;
    logic               res_fb;
    logic [CNT_W-1:0]   res_cnt;
    logic [IDX_W-1:0]   idx_sel;
    logic [31:0]        tick_new;

    tklru_pkg::cmd_t    cmd;
    logic [IDX_W-1:0]   cmd_idx;

    logic [ENTRIES:0]   ch_act;
    tklru_pkg::srch_t   ch_srch [ENTRIES+1];
    logic [IDX_W-1:0]   ch_midx [ENTRIES+1];
    logic [IDX_W-1:0]   ch_iidx [ENTRIES+1];
    logic [IDX_W-1:0]   ch_nidx [ENTRIES+1];
    logic [CNT_W-1:0]   ch_cnt  [ENTRIES+1];

    assign ch_act[0]  = start_reg;
    assign ch_srch[0] = '0;
    assign ch_midx[0] = '0;
    assign ch_iidx[0] = '0;
    assign ch_nidx[0] = '0;
    assign ch_cnt[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tklru_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .tin_act        (ch_act[g]),
            .tin            (ch_srch[g]),
            .tin_match_idx  (ch_midx[g]),
            .tin_inv_idx    (ch_iidx[g]),
            .tin_min_idx    (ch_nidx[g]),
            .tin_count      (ch_cnt[g]),
            .tout_act       (ch_act[g+1]),
            .tout           (ch_srch[g+1]),
            .tout_match_idx (ch_midx[g+1]),
            .tout_inv_idx   (ch_iidx[g+1]),
            .tout_min_idx   (ch_nidx[g+1]),
            .tout_count     (ch_cnt[g+1]),
            .cmd            (cmd),
            .cmd_idx        (cmd_idx)
        );
    end

    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        accept   = in_valid && !in_stall;
        out_free = !out_valid_reg || !out_stall;
        commit   = (state_reg == S_FIN) && out_free;
        size_ok  = (size_reg != 18'd0) && (size_reg <= tklru_pkg::MAX_TILE_BYTES);
        tick_inc = tick_reg + 32'd1;

        tick_new = tick_reg;
        wr_full  = 1'b0;
        wr_stamp = 1'b0;
        wr_flush = 1'b0;
        idx_sel  = fin_midx_reg;
        res_hit  = 1'b0;
        res_slot = 3'd0;
        res_size = 18'd0;
        res_acc  = 1'b0;
        res_fb   = 1'b0;
        res_cnt  = '0;

        case (func_reg)
            tklru_pkg::FUNC_LOOKUP:
            begin
                res_cnt = fin_cnt_reg;
                if (fin_reg.match_found)
                begin
                    wr_stamp = 1'b1;
                    tick_new = tick_inc;
                    res_hit  = 1'b1;
                    res_slot = 3'(fin_midx_reg);
                    res_size = {1'b0, fin_reg.match_bytes} + 18'd1;
                end
                else
                begin
                    res_fb = 1'b1;
                end
            end
            tklru_pkg::FUNC_INSERT:
            begin
                res_cnt = fin_cnt_reg;
                if (size_ok)
                begin
                    if (fin_reg.match_found)
                    begin
                        idx_sel = fin_midx_reg;
                    end
                    else if (fin_reg.inv_found)
                    begin
                        idx_sel = fin_iidx_reg;
                        res_cnt = fin_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        idx_sel = fin_nidx_reg;
                    end
                    wr_full  = 1'b1;
                    tick_new = tick_inc;
                    res_acc  = 1'b1;
                    res_slot = 3'(idx_sel);
                end
            end
            tklru_pkg::FUNC_FLUSH:
            begin
                wr_flush = 1'b1;
            end
            tklru_pkg::FUNC_CLEAR:
            begin
                wr_flush = 1'b1;
                tick_new = 32'd0;
            end
            default:
            begin
                res_cnt = '0;
            end
        endcase

        tick_next = commit ? tick_new : tick_reg;

        cmd.full       = commit && wr_full;
        cmd.stamp_only = commit && wr_stamp;
        cmd.flush      = commit && wr_flush;
        cmd.zoom       = zoom_reg;
        cmd.col        = x_reg;
        cmd.row        = y_reg;
        cmd.bytes      = 17'(size_reg - 18'd1);
        cmd.stamp      = tick_inc;
        cmd_idx        = idx_sel;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (ch_act[ENTRIES])
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            tick_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            tick_reg  <= tick_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= tklru_pkg::func_t'(func);
            zoom_reg <= zoom;
            x_reg    <= tile_x;
            y_reg    <= tile_y;
            size_reg <= tile_size;
        end
        if ((state_reg == S_RUN) && ch_act[ENTRIES])
        begin
            fin_reg      <= ch_srch[ENTRIES];
            fin_midx_reg <= ch_midx[ENTRIES];
            fin_iidx_reg <= ch_iidx[ENTRIES];
            fin_nidx_reg <= ch_nidx[ENTRIES];
            fin_cnt_reg  <= ch_cnt[ENTRIES];
        end
        if (commit)
        begin
            hit_reg      <= res_hit;
            slot_reg     <= res_slot;
            size_out_reg <= res_size;
            accepted_reg <= res_acc;
            fallback_reg <= res_fb;
            cnt_reg      <= res_cnt;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign stored_size  = size_out_reg;
    assign accepted     = accepted_reg;
    assign use_fallback = fallback_reg;
    assign valid_count  = 4'(cnt_reg);

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RUN))
        else $error("transfer did not start a search");

    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ch_act[ENTRIES] |-> (state_reg == S_RUN))
        else $error("search token left the chain outside the run state");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(hit_reg && fallback_reg) && !(hit_reg && accepted_reg)))
        else $error("conflicting result flags");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cnt_reg <= CNT_W'(ENTRIES)))
        else $error("valid count above entry count");

endmodule
